// ===== design/forest_fire_grid_step_core_assert.svh =====
// Assertion macros for the checker of the forest fire grid core.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FOREST_FIRE_GRID_STEP_CORE_ASSERT_SVH
`define FOREST_FIRE_GRID_STEP_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FFGS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FFGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ffgs_pkg.sv =====
// Package for the forest fire grid core: cell codes, command codes,
// stream widths, the sequencer state type and the neighbor mask struct.
`timescale 1ns / 1ps

package ffgs_pkg;

  localparam int CMD_W       = 2;
  localparam int COORD_W     = 4;
  localparam int CELL_W      = 2;
  localparam int COUNT_W     = 9;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef logic [CELL_W-1:0] cell_t;

  localparam cell_t CELL_TREE    = 2'd0;
  localparam cell_t CELL_BURNING = 2'd1;
  localparam cell_t CELL_BURNT   = 2'd2;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'h1FF;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDWAIT,
    S_STEP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } nbr_mask_t;

endpackage

// ===== design/ffgs_cell_upd.sv =====
// Cell update rule of the forest fire automaton for one 3x3 window.
// Depends on ffgs_pkg for the cell codes and the neighbor mask struct.
`timescale 1ns / 1ps

module ffgs_cell_upd (
  input  ffgs_pkg::cell_t [8:0] win,
  input  ffgs_pkg::nbr_mask_t   mask,
  output ffgs_pkg::cell_t       next_cell,
  output logic                  next_burning
);
  import ffgs_pkg::*;

  logic [8:0] burn;
  logic [8:0] keep;
  logic       fire_near;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      burn[i] = (win[i] == CELL_BURNING);
    end
    keep[0] = mask.up & mask.lf;
    keep[1] = mask.up;
    keep[2] = mask.up & mask.rt;
    keep[3] = mask.lf;
    keep[4] = 1'b0;
    keep[5] = mask.rt;
    keep[6] = mask.dn & mask.lf;
    keep[7] = mask.dn;
    keep[8] = mask.dn & mask.rt;
    fire_near = |(burn & keep);

    if (win[4] == CELL_TREE) begin
      next_cell = fire_near ? CELL_BURNING : CELL_TREE;
    end else if (win[4] == CELL_BURNING) begin
      next_cell = CELL_BURNT;
    end else begin
      next_cell = win[4];
    end
    next_burning = (next_cell == CELL_BURNING);
  end

endmodule

// ===== design/forest_fire_grid_step_core.sv =====
// Forest fire grid core: one command beat in, one result beat out.
// The slave side carries a command: write a cell, read a cell, or advance
// the whole grid by one generation. The master side returns the value read
// (zero for anything but a read) and the number of burning cells after the
// most recent step.
// After reset the core clears its grid to all trees, with s_tready low
// until the clear is done.
// One command is worked on at a time. A write or an unused command goes
// through S_DONE to the output register; a read goes through S_RDWAIT first.
// A step streams every cell once through a single cell updater fed by one
// memory read port and a window shift line of two grid rows plus three
// cells.
// The grid lives in a two-bank memory; a step reads one bank, writes the
// other and then swaps them.
// A result waits in the output register while the receiver stalls; the core
// still accepts the next command, but holds its result until the register
// is free.
// Depends on ffgs_pkg and ffgs_cell_upd.
`timescale 1ns / 1ps

module forest_fire_grid_step_core #(
  parameter int GRID_SIZE = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // command[1:0], row[5:2], column[9:6], cell_value[11:10], zeros above.
  input  logic [ffgs_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // read_value[1:0], burning_count[10:2], zeros above.
  output logic [ffgs_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import ffgs_pkg::*;

  localparam int N   = GRID_SIZE * GRID_SIZE;
  localparam int AW  = $clog2(N);
  localparam int MW  = AW + 1;
  localparam int SW  = $clog2(N + GRID_SIZE + 4);
  localparam int CW  = $clog2(GRID_SIZE);
  localparam int SHL = 2 * GRID_SIZE + 3;

  state_t state, state_next;

  logic [CMD_W-1:0]   command;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] column;
  cell_t              cell_value;
  logic               on_grid;
  logic [AW-1:0]      cmd_addr;

  cell_t              mem [2**MW];
  logic               mem_we;
  logic               mem_re;
  logic [MW-1:0]      mem_waddr;
  logic [MW-1:0]      mem_raddr;
  cell_t              mem_wdata;
  cell_t              rd_data;

  logic               bank;
  logic [AW-1:0]      clr_addr;
  logic [SW-1:0]      scan;
  logic               step_d;
  logic               feed_real;
  cell_t [SHL-1:0]    sh;
  logic [AW-1:0]      cidx;
  logic [CW-1:0]      crow;
  logic [CW-1:0]      ccol;
  logic               proc;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] cnt_next;
  logic [COUNT_W-1:0] fire_count;

  cell_t              res_val;
  logic               res_on;
  logic               load_out;

  cell_t [8:0]        win;
  nbr_mask_t          mask;
  cell_t              upd_cell;
  logic               upd_burning;

  assign command    = s_tdata[1:0];
  assign row        = s_tdata[5:2];
  assign column     = s_tdata[9:6];
  assign cell_value = s_tdata[11:10];

  assign on_grid  = ({3'b000, row} < 7'(GRID_SIZE)) && ({3'b000, column} < 7'(GRID_SIZE));
  assign cmd_addr = AW'(row) * AW'(GRID_SIZE) + AW'(column);

  assign proc = (state == S_STEP) && (scan >= SW'(GRID_SIZE + 3));

  always_comb begin
    win[0] = sh[2*GRID_SIZE+2];
    win[1] = sh[2*GRID_SIZE+1];
    win[2] = sh[2*GRID_SIZE];
    win[3] = sh[GRID_SIZE+2];
    win[4] = sh[GRID_SIZE+1];
    win[5] = sh[GRID_SIZE];
    win[6] = sh[2];
    win[7] = sh[1];
    win[8] = sh[0];
    mask.up = (crow != '0);
    mask.dn = (crow != CW'(GRID_SIZE - 1));
    mask.lf = (ccol != '0);
    mask.rt = (ccol != CW'(GRID_SIZE - 1));
  end

  ffgs_cell_upd u_upd (
    .win          (win),
    .mask         (mask),
    .next_cell    (upd_cell),
    .next_burning (upd_burning)
  );

  assign cnt_next = (upd_burning && (cnt != COUNT_MAX)) ? cnt + 1'b1 : cnt;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = {bank, cmd_addr};
    mem_raddr  = {bank, cmd_addr};
    mem_wdata  = cell_value;
    load_out   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {bank, clr_addr};
        mem_wdata = CELL_TREE;
        if (clr_addr == AW'(N - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (command)
            CMD_WRITE: begin
              mem_we     = on_grid;
              state_next = S_DONE;
            end
            CMD_STEP: begin
              state_next = S_STEP;
            end
            CMD_READ: begin
              mem_re     = 1'b1;
              state_next = S_RDWAIT;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        state_next = S_DONE;
      end
      S_STEP: begin
        mem_re    = (scan < SW'(N));
        mem_raddr = {bank, AW'(scan)};
        if (proc) begin
          mem_we    = 1'b1;
          mem_waddr = {~bank, cidx};
          mem_wdata = upd_cell;
          if (cidx == AW'(N - 1)) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      bank       <= 1'b0;
      clr_addr   <= '0;
      fire_count <= '0;
      step_d     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state  <= state_next;
      step_d <= (state == S_STEP);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (proc && (cidx == AW'(N - 1))) begin
        fire_count <= cnt_next;
        bank       <= ~bank;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    feed_real <= (scan < SW'(N));
    if (step_d) begin
      sh <= {sh[SHL-2:0], feed_real ? rd_data : CELL_TREE};
    end
    if (state == S_IDLE) begin
      res_val <= CELL_TREE;
      res_on  <= on_grid;
      scan    <= '0;
      cidx    <= '0;
      crow    <= '0;
      ccol    <= '0;
      cnt     <= '0;
    end
    if (state == S_RDWAIT) begin
      res_val <= res_on ? rd_data : CELL_TREE;
    end
    if (state == S_STEP) begin
      scan <= scan + 1'b1;
      if (proc) begin
        cidx <= cidx + 1'b1;
        cnt  <= cnt_next;
        if (ccol == CW'(GRID_SIZE - 1)) begin
          ccol <= '0;
          crow <= crow + 1'b1;
        end else begin
          ccol <= ccol + 1'b1;
        end
      end
    end
    if (load_out) begin
      m_tdata <= {(OUT_TDATA_W - COUNT_W - CELL_W)'(0), fire_count, res_val};
    end
  end

endmodule

// ===== design/ffgs_port_check.sv =====
// Port checker for the forest fire grid core, bound to the top level.
// Depends on ffgs_pkg and the macros in forest_fire_grid_step_core_assert.svh.
`timescale 1ns / 1ps
`include "forest_fire_grid_step_core_assert.svh"

module ffgs_port_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [ffgs_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ffgs_pkg::*;

  `FFGS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result beat changed")
  `FFGS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "core ready again right after a command beat")
  `FFGS_ASSERT_SAME(a_out_pad, m_tvalid, m_tdata[OUT_TDATA_W-1:COUNT_W+CELL_W] == '0, "result padding bits not zero")
  `FFGS_ASSERT_SAME(a_hs_known, 1'b1, !$isunknown(s_tready) && !$isunknown(m_tvalid), "handshake output unknown after reset")

endmodule

bind forest_fire_grid_step_core ffgs_port_check u_port_check (.*);
